// File: rtl/core/ordered_sequence_store_defines.svh
// ----------------------------------------------------------------------------
// ordered_sequence_store_defines
// Assertion macros shared by the ordered sequence store modules.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SEQUENCE_STORE_DEFINES_SVH
`define ORDERED_SEQUENCE_STORE_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define OSS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the same cycle as the trigger.
`define OSS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define OSS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/oss_pkg.sv
// ----------------------------------------------------------------------------
// oss_pkg
// Types and constants of the ordered sequence store.
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int unsigned OSS_CAPACITY = 64;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_REAR  = 3'd3,
    OP_INS_POS   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [6:0]         position;
  } oss_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic [6:0]         count;
  } oss_rsp_t;

  typedef struct packed {
    logic load_req;
    logic commit;
  } dp_cmd_t;

endpackage

// File: rtl/core/oss_ctrl.sv
// ----------------------------------------------------------------------------
// oss_ctrl
// Controller: takes a request, schedules its commit and owns the output valid.
// ----------------------------------------------------------------------------
`include "ordered_sequence_store_defines.svh"

module oss_ctrl import oss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = (state_q != S_IDLE);
    cmd_o.load_req = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit   = (state_q == S_EXEC) && slot_free;
    // hold the result while stalled, load a fresh one on commit
    out_valid_d    = cmd_o.commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `OSS_ASSERT_NEXT(a_load_to_exec, clk_i, rst_ni, cmd_o.load_req, state_q == S_EXEC,
    "accepted request did not move to execution")
  `OSS_ASSERT_NEXT(a_commit_gives_valid, clk_i, rst_ni, cmd_o.commit, out_valid_q,
    "commit did not present a result")
  `OSS_ASSERT_NOW(a_no_commit_over_result, clk_i, rst_ni, out_valid_q && out_stall_i,
    !cmd_o.commit, "commit would overwrite a stalled result")

endmodule

// File: rtl/core/oss_datapath.sv
// ----------------------------------------------------------------------------
// oss_datapath
// Row of entry cells with parallel shift, entry count and result register.
// ----------------------------------------------------------------------------
`include "ordered_sequence_store_defines.svh"

module oss_datapath import oss_pkg::*; #(
  parameter int unsigned Capacity = OSS_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  input  oss_req_t in_req_i,
  output oss_rsp_t out_rsp_o
);

  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned WideW = CntW + 8;

  oss_req_t           req_q;
  oss_rsp_t           rsp_q, rsp_d;
  logic [CntW-1:0]    count_q, count_d;
  logic signed [31:0] cells_q [Capacity];
  logic signed [31:0] cells_d [Capacity];

  logic [WideW-1:0]   cnt_wide, pos_wide, pos_m1;
  logic [CntW-1:0]    cnt_m1;
  logic [CntW+6:0]    cnt_out_wide;
  logic               is_full, is_empty, pos_bad;
  logic               do_ins, do_rem_front, do_rem_rear;
  logic [CntW-1:0]    ins_idx;
  status_e            status;
  logic signed [31:0] removed;

  assign cnt_wide = {8'b0, count_q};
  assign pos_wide = {{(CntW + 1){1'b0}}, req_q.position};
  assign pos_m1   = pos_wide - WideW'(1);
  assign cnt_m1   = count_q - CntW'(1);
  assign is_full  = (count_q == CntW'(Capacity));
  assign is_empty = (count_q == '0);
  assign pos_bad  = (pos_wide == '0) || (pos_wide > cnt_wide + WideW'(1));

  always_comb begin
    status       = ST_OK;
    do_ins       = 1'b0;
    do_rem_front = 1'b0;
    do_rem_rear  = 1'b0;
    ins_idx      = '0;
    unique case (req_q.op)
      OP_INS_FRONT: begin
        if (is_full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_REAR: begin
        ins_idx = count_q;
        if (is_full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_REM_FRONT: begin
        if (is_empty) status = ST_EMPTY;
        else do_rem_front = 1'b1;
      end
      OP_REM_REAR: begin
        if (is_empty) status = ST_EMPTY;
        else do_rem_rear = 1'b1;
      end
      OP_INS_POS: begin
        ins_idx = pos_m1[CntW-1:0];
        if (pos_bad) status = ST_BADPOS;
        else if (is_full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.commit) begin
      if (do_ins) count_d = count_q + CntW'(1);
      else if (do_rem_front || do_rem_rear) count_d = cnt_m1;
    end
  end

  always_comb begin
    if (do_rem_front) removed = cells_q[0];
    else if (do_rem_rear) removed = cells_q[cnt_m1[AddrW-1:0]];
    else removed = '0;
  end

  assign cnt_out_wide        = {7'b0, count_d};
  assign rsp_d.status        = status;
  assign rsp_d.removed_value = removed;
  assign rsp_d.count         = cnt_out_wide[6:0];

  // Each cell looks only at its neighbours and the request value: later entries
  // move rearward on an insert, every entry moves frontward on a front removal.
  for (genvar k = 0; k < Capacity; k++) begin : g_cell
    always_comb begin
      cells_d[k] = cells_q[k];
      if (do_ins) begin
        if (CntW'(k) == ins_idx) begin
          cells_d[k] = req_q.value;
        end else if (CntW'(k) > ins_idx) begin
          if (k > 0) cells_d[k] = cells_q[(k > 0) ? k - 1 : 0];
        end
      end else if (do_rem_front) begin
        if (k < Capacity - 1) cells_d[k] = cells_q[(k < Capacity - 1) ? k + 1 : k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        cells_q[k] <= cells_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign out_rsp_o = rsp_q;

  `OSS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Capacity),
    "entry count above capacity")
  `OSS_ASSERT_NEXT(a_error_keeps_count, clk_i, rst_ni, cmd_i.commit && status != ST_OK,
    count_q == $past(count_q), "failed request changed the count")
  `OSS_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, cmd_i.commit && do_ins,
    count_q == $past(count_q) + CntW'(1), "insert did not grow the count")

endmodule

// File: rtl/core/ordered_sequence_store.sv
// ----------------------------------------------------------------------------
// ordered_sequence_store
// Bounded ordered list of signed 32-bit values with front, rear and
// positional insert and front and rear removal.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the in channel (in_valid_i / in_stall_o)
// carries an op, a value and a 1-based position. Every request yields one
// response transaction on the out channel (out_valid_o / out_stall_i) with a
// status, the removed value (zero unless a removal succeeded) and the count
// after the request. Failed requests leave the list unchanged.
// The request is registered when it is taken; in the execute step it is
// committed across the whole cell row, which shifts in parallel, and the
// response is registered. A new request is not taken until that commit.
// A stalled response sits in the output register; the next request is still
// taken and waits at its commit step until the response is taken.
// Reset empties the list at once; entry contents are not cleared and are
// never read before being written.
// ----------------------------------------------------------------------------
module ordered_sequence_store import oss_pkg::*; #(
  parameter int unsigned CAPACITY = OSS_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  oss_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output oss_rsp_t out_rsp_o
);

  dp_cmd_t cmd;

  oss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  oss_datapath #(
    .Capacity (CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o)
  );

endmodule
